// File: design/a64lsu_pkg.sv
// shared types and constants for the load/store unit
package a64lsu_pkg;

    // memory depth in 32-bit words, a power of two
    localparam int MEM_WORDS = 4096;
    localparam int IDX_W     = $clog2(MEM_WORDS);

    // instruction word fields
    localparam int RT_LSB     = 0;
    localparam int XN_LSB     = 5;
    localparam int IMM12_LSB  = 10;
    localparam int LOAD_BIT   = 22;
    localparam int UOFF_BIT   = 24;
    localparam int XFORM_BIT  = 30;
    // bits inside imm12
    localparam int REGOFF_BIT = 11;
    localparam int PRE_BIT    = 1;
    localparam int IMM9_LSB   = 2;

    // decoded operation handed from front to back
    typedef struct packed {
        logic             is_load;
        logic             is_x;
        logic [1:0]       lane;
        logic [1:0]       last_word;
        logic [IDX_W-1:0] word_idx;
        logic [95:0]      st_data;
        logic [11:0]      st_mask;
        logic [4:0]       dest;
        logic             wb_valid;
        logic [4:0]       wb_reg;
        logic [63:0]      wb_value;
    } op_t;

endpackage

// File: design/a64lsu_ram.sv
// generic single-write, single-read ram with registered read data
module a64lsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/a64lsu_front.sv
// front end: decode, address generation and store lane alignment
module a64lsu_front (
    input  logic [31:0]       instruction,
    input  logic [63:0]       base_value,
    input  logic [63:0]       offset_value,
    input  logic [63:0]       store_value,
    output a64lsu_pkg::op_t   op
);
    import a64lsu_pkg::*;

    logic [4:0]  rt;
    logic [4:0]  xn;
    logic [11:0] imm12;
    logic        is_load;
    logic        is_uoff;
    logic        is_x;
    logic        is_regoff;
    logic        is_pre;
    logic [63:0] simm9;
    logic [63:0] scaled;
    logic [63:0] operand;
    logic [63:0] sum;
    logic [63:0] addr;
    logic [1:0]  lane;
    logic [3:0]  end_byte;
    logic [11:0] base_mask;

    always_comb
    begin
        rt        = instruction[RT_LSB +: 5];
        xn        = instruction[XN_LSB +: 5];
        imm12     = instruction[IMM12_LSB +: 12];
        is_load   = instruction[LOAD_BIT];
        is_uoff   = instruction[UOFF_BIT];
        is_x      = instruction[XFORM_BIT];
        is_regoff = imm12[REGOFF_BIT];
        is_pre    = imm12[PRE_BIT];

        simm9  = {{55{imm12[IMM9_LSB+8]}}, imm12[IMM9_LSB +: 9]};
        scaled = is_x ? {49'b0, imm12, 3'b0} : {50'b0, imm12, 2'b0};

        // one adder serves all four modes
        if (is_uoff)
        begin
            operand = scaled;
        end
        else if (is_regoff)
        begin
            operand = offset_value;
        end
        else
        begin
            operand = simm9;
        end
        sum  = base_value + operand;
        addr = (!is_uoff && !is_regoff && !is_pre) ? base_value : sum;

        lane      = addr[1:0];
        end_byte  = {2'b0, lane} + (is_x ? 4'd7 : 4'd3);
        base_mask = is_x ? 12'h0ff : 12'h00f;

        op.is_load   = is_load;
        op.is_x      = is_x;
        op.lane      = lane;
        op.last_word = end_byte[3:2];
        op.word_idx  = addr[IDX_W+1:2];
        op.st_data   = {32'b0, store_value} << {lane, 3'b0};
        op.st_mask   = base_mask << lane;
        op.dest      = is_load ? rt : 5'd0;
        op.wb_valid  = !is_uoff && !is_regoff;
        op.wb_reg    = (!is_uoff && !is_regoff) ? xn : 5'd0;
        op.wb_value  = (!is_uoff && !is_regoff) ? sum : 64'd0;
    end

endmodule

// File: design/a64lsu_fifo.sv
// two-entry queue of decoded operations between front and back
module a64lsu_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  a64lsu_pkg::op_t   din,
    output logic              full,
    input  logic              pop,
    output a64lsu_pkg::op_t   dout,
    output logic              empty
);
    import a64lsu_pkg::*;

    op_t        entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/a64lsu_back.sv
// back end: memory clear, word-by-word read-modify-write, result register
module a64lsu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  a64lsu_pkg::op_t   q_dout,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              clear_done,
    output logic              empty,
    input  logic              pop,
    output logic              load_valid,
    output logic [63:0]       load_data,
    output logic [4:0]        dest_register,
    output logic              writeback_valid,
    output logic [4:0]        writeback_register,
    output logic [63:0]       writeback_value
);
    import a64lsu_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MERGE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] clr_cnt_next;
    op_t              op_reg;
    op_t              op_next;
    logic [1:0]       word_cnt_reg;
    logic [1:0]       word_cnt_next;
    logic [95:0]      win_reg;
    logic [95:0]      win_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             ld_valid_reg;
    logic [63:0]      ld_data_reg;
    logic [4:0]       dest_reg;
    logic             wb_valid_reg;
    logic [4:0]       wb_reg_reg;
    logic [63:0]      wb_value_reg;
    logic             out_load;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [31:0]      ram_wdata;
    logic [IDX_W-1:0] cur_addr;
    logic [31:0]      rdata;
    logic [31:0]      merged;
    logic [3:0]       lane_mask;
    logic [31:0]      lane_data;
    logic [95:0]      shifted;
    logic [63:0]      ld_value;
    logic             out_pop;

    a64lsu_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_addr),
        .rdata (rdata)
    );

    assign cur_addr   = op_reg.word_idx + IDX_W'(word_cnt_reg);
    assign out_pop    = pop && out_valid_reg;
    assign clear_done = (state_reg != ST_CLEAR);

    always_comb
    begin
        lane_mask = op_reg.st_mask[word_cnt_reg*4 +: 4];
        lane_data = op_reg.st_data[word_cnt_reg*32 +: 32];
        for (int l = 0; l < 4; l++)
        begin
            merged[l*8 +: 8] = lane_mask[l] ? lane_data[l*8 +: 8] : rdata[l*8 +: 8];
        end

        shifted  = win_reg >> {op_reg.lane, 3'b0};
        ld_value = op_reg.is_x ? shifted[63:0] : {32'b0, shifted[31:0]};
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        op_next        = op_reg;
        word_cnt_next  = word_cnt_reg;
        win_next       = win_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cur_addr;
        ram_wdata      = merged;
        out_load       = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = 32'd0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(MEM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    op_next       = q_dout;
                    word_cnt_next = 2'd0;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                ram_we = !op_reg.is_load;
                win_next[word_cnt_reg*32 +: 32] = rdata;
                if (word_cnt_reg == op_reg.last_word)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    word_cnt_next = word_cnt_reg + 2'd1;
                    state_next    = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_pop)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        word_cnt_reg <= word_cnt_next;
        win_reg      <= win_next;
        if (out_load)
        begin
            ld_valid_reg <= op_reg.is_load;
            ld_data_reg  <= op_reg.is_load ? ld_value : 64'd0;
            dest_reg     <= op_reg.dest;
            wb_valid_reg <= op_reg.wb_valid;
            wb_reg_reg   <= op_reg.wb_reg;
            wb_value_reg <= op_reg.wb_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty              = !out_valid_reg;
    assign load_valid         = ld_valid_reg;
    assign load_data          = ld_data_reg;
    assign dest_register      = dest_reg;
    assign writeback_valid    = wb_valid_reg;
    assign writeback_register = wb_reg_reg;
    assign writeback_value    = wb_value_reg;

endmodule

// File: design/a64_load_store_unit_core.sv
// top level of the load/store unit: front end, operation queue and back end
//
// channel  direction  handshake           payload
// request  in         push / full         instruction, base_value, offset_value, store_value
// result   out        pop / empty         load_valid, load_data, dest_register,
//                                         writeback_valid, writeback_register, writeback_value
//
// each beat walks the back end through idle, a read and a merge state for each
// 32-bit word it touches (1 to 3), then done, where it waits while the result
// register holds an unpopped result; the next beat leaves the queue only after
// that; after reset the back end zeroes all MEM_WORDS (4096) ram words, one
// word a cycle; full stays high meanwhile
// a two-entry queue lets the front keep taking beats while the back works,
// and a result register lets the back finish while a result waits for pop
module a64_load_store_unit_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] instruction,
    input  logic [63:0] base_value,
    input  logic [63:0] offset_value,
    input  logic [63:0] store_value,
    output logic        empty,
    input  logic        pop,
    output logic        load_valid,
    output logic [63:0] load_data,
    output logic [4:0]  dest_register,
    output logic        writeback_valid,
    output logic [4:0]  writeback_register,
    output logic [63:0] writeback_value
);
    import a64lsu_pkg::*;

    op_t  front_op;
    op_t  q_dout;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic q_push;
    logic clear_done;

    // decode and address generation, purely combinational
    a64lsu_front u_front (
        .instruction  (instruction),
        .base_value   (base_value),
        .offset_value (offset_value),
        .store_value  (store_value),
        .op           (front_op)
    );

    // no beats until the ram clear has run
    assign full   = q_full || !clear_done;
    assign q_push = push && !full;

    a64lsu_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (front_op),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    // memory sequencer and result register
    a64lsu_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_dout             (q_dout),
        .q_empty            (q_empty),
        .q_pop              (q_pop),
        .clear_done         (clear_done),
        .empty              (empty),
        .pop                (pop),
        .load_valid         (load_valid),
        .load_data          (load_data),
        .dest_register      (dest_register),
        .writeback_valid    (writeback_valid),
        .writeback_register (writeback_register),
        .writeback_value    (writeback_value)
    );

endmodule

// File: tb/a64_load_store_unit_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the load/store unit core, with its own memory image predictor
module a64_load_store_unit_core_tb;

    import a64lsu_pkg::*;

    // instruction bits the unit decodes; everything else must be ignored
    localparam logic [31:0] DECODED_BITS = 32'h003F_FFFF | (32'h1 << LOAD_BIT)
                                         | (32'h1 << UOFF_BIT) | (32'h1 << XFORM_BIT);

    // one result beat as the unit reports it
    typedef struct packed {
        logic        load_valid;
        logic [63:0] load_data;
        logic [4:0]  dest;
        logic        wb_valid;
        logic [4:0]  wb_reg;
        logic [63:0] wb_value;
    } xfer_result_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [31:0] instruction;
    logic [63:0] base_value;
    logic [63:0] offset_value;
    logic [63:0] store_value;
    logic        empty;
    logic        pop;
    logic        load_valid;
    logic [63:0] load_data;
    logic [4:0]  dest_register;
    logic        writeback_valid;
    logic [4:0]  writeback_register;
    logic [63:0] writeback_value;

    // predictor state: byte image of the word ram, cleared like the ram at reset
    logic [31:0]  mem_image [MEM_WORDS];
    xfer_result_t expected_results [$];

    // pacing knobs shared between the stimulus tasks and the drain process
    logic send_eager;
    logic recv_eager;
    int   hold_off_cycles;

    int error_count;
    int n_loads;
    int n_stores;
    int n_writebacks;
    int n_results;

    a64_load_store_unit_core i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run (ram clear plus ~1300 beats)
    initial
    begin
        #2_000_000;
        $display("a64_load_store_unit_core_tb failed");
        $finish;
    end

    // assemble an instruction word from its decoded fields
    function automatic logic [31:0] make_ins(input logic is_x, input logic is_load,
                                             input logic is_uoff, input logic [11:0] imm12,
                                             input logic [4:0] xn, input logic [4:0] rt);
        logic [31:0] w;
        w = '0;
        w[RT_LSB +: 5]     = rt;
        w[XN_LSB +: 5]     = xn;
        w[IMM12_LSB +: 12] = imm12;
        w[LOAD_BIT]        = is_load;
        w[UOFF_BIT]        = is_uoff;
        w[XFORM_BIT]       = is_x;
        return w;
    endfunction

    // imm12 for pre/post index: signed imm9 in bits 10:2, pre flag in bit 1
    function automatic logic [11:0] index_imm(input logic [8:0] imm9, input logic pre);
        return {1'b0, imm9, pre, 1'b0};
    endfunction

    // executes one transfer on the memory image and returns what the unit must report
    function automatic xfer_result_t model_transfer(input logic [31:0] ins,
                                                    input logic [63:0] base,
                                                    input logic [63:0] off,
                                                    input logic [63:0] st);
        xfer_result_t     r;
        logic [11:0]      imm12;
        logic [63:0]      addr;
        logic [63:0]      byte_addr;
        logic [63:0]      data;
        logic [63:0]      wbv;
        logic [IDX_W-1:0] idx;
        logic [1:0]       lane;
        int               nbytes;
        int               k;
        r      = '0;
        data   = '0;
        imm12  = ins[IMM12_LSB +: 12];
        nbytes = ins[XFORM_BIT] ? 8 : 4;
        if (ins[UOFF_BIT])
        begin
            // scaled by the access size
            addr = base + (ins[XFORM_BIT] ? {imm12, 3'b000} : {imm12, 2'b00});
        end
        else if (imm12[REGOFF_BIT])
        begin
            // register offset, added unscaled
            addr = base + off;
        end
        else
        begin
            wbv        = base + {{55{imm12[IMM9_LSB + 8]}}, imm12[IMM9_LSB +: 9]};
            r.wb_valid = 1'b1;
            r.wb_reg   = ins[XN_LSB +: 5];
            r.wb_value = wbv;
            addr       = imm12[PRE_BIT] ? wbv : base;
        end
        // byte by byte, so unaligned accesses and both kinds of wrap fall out naturally
        for (k = 0; k < nbytes; k++)
        begin
            byte_addr = addr + 64'(k);
            idx       = byte_addr[IDX_W+1:2];
            lane      = byte_addr[1:0];
            if (ins[LOAD_BIT])
                data[8*k +: 8] = mem_image[idx][8*lane +: 8];
            else
                mem_image[idx][8*lane +: 8] = st[8*k +: 8];
        end
        if (ins[LOAD_BIT])
        begin
            r.load_valid = 1'b1;
            r.load_data  = data;
            r.dest       = ins[RT_LSB +: 5];
        end
        return r;
    endfunction

    // offer one request beat, after a random gap unless send_eager is set; predict it at the accepting edge
    task automatic send_beat(input logic [31:0] ins, input logic [63:0] base,
                             input logic [63:0] off, input logic [63:0] st);
        int gap;
        gap = send_eager ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        instruction  <= ins;
        base_value   <= base;
        offset_value <= off;
        store_value  <= st;
        // full stays high through the post-reset ram clear, so this covers that too
        do
            @(posedge clk);
        while (full);
        expected_results.push_back(model_transfer(ins, base, off, st));
        if (ins[LOAD_BIT])
            n_loads++;
        else
            n_stores++;
        if (!ins[UOFF_BIT] && !ins[IMM12_LSB + REGOFF_BIT])
            n_writebacks++;
    endtask

    // stop offering and wait for every outstanding result beat
    task automatic wait_drained();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // compare one accepted result beat against the oldest prediction
    task automatic check_result();
        xfer_result_t exp_r;
        n_results++;
        if (expected_results.size() == 0)
        begin
            $error("result beat with nothing expected");
            error_count++;
        end
        else
        begin
            exp_r = expected_results.pop_front();
            if (load_valid !== exp_r.load_valid)
            begin
                $error("load_valid: expected %0b, got %0b", exp_r.load_valid, load_valid);
                error_count++;
            end
            if (load_data !== exp_r.load_data)
            begin
                $error("load_data: expected %h, got %h", exp_r.load_data, load_data);
                error_count++;
            end
            if (dest_register !== exp_r.dest)
            begin
                $error("dest_register: expected %0d, got %0d", exp_r.dest, dest_register);
                error_count++;
            end
            if (writeback_valid !== exp_r.wb_valid)
            begin
                $error("writeback_valid: expected %0b, got %0b", exp_r.wb_valid,
                       writeback_valid);
                error_count++;
            end
            if (writeback_register !== exp_r.wb_reg)
            begin
                $error("writeback_register: expected %0d, got %0d", exp_r.wb_reg,
                       writeback_register);
                error_count++;
            end
            if (writeback_value !== exp_r.wb_value)
            begin
                $error("writeback_value: expected %h, got %h", exp_r.wb_value,
                       writeback_value);
                error_count++;
            end
        end
    endtask

    // result side: random pop stalls, plus the long hold-off when one is requested
    initial
    begin : result_drain
        int stall;
        pop = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = recv_eager ? 0 : $urandom_range(0, 4);
            if (hold_off_cycles > 0)
            begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            check_result();
        end
    end

    // field extremes, every addressing mode, unaligned and wrapping accesses
    task automatic test_directed();
        // x store then load at address 0
        send_beat(make_ins(1'b1, 1'b0, 1'b1, 12'h000, 5'd2, 5'd1), 64'h0, 64'h0,
                  64'h0123_4567_89AB_CDEF);
        send_beat(make_ins(1'b1, 1'b1, 1'b1, 12'h000, 5'd2, 5'd3), 64'h0, 64'h0, 64'h0);
        // largest scaled offset, w form: lands on the last ram word
        send_beat(make_ins(1'b0, 1'b0, 1'b1, 12'hFFF, 5'd0, 5'd4), 64'h0, 64'h0, '1);
        send_beat(make_ins(1'b0, 1'b1, 1'b1, 12'hFFF, 5'd0, 5'd5), 64'h0, 64'h0, 64'h0);
        // largest scaled offset, x form: word index wraps past the ram depth
        send_beat(make_ins(1'b1, 1'b0, 1'b1, 12'hFFF, 5'd6, 5'd6), 64'h0, 64'h0,
                  64'hFEDC_BA98_7654_3210);
        send_beat(make_ins(1'b1, 1'b1, 1'b1, 12'h000, 5'd6, 5'd7), 64'd32760, 64'h0, 64'h0);
        // register offset, unaligned x store across three words, read back shifted
        send_beat(make_ins(1'b1, 1'b0, 1'b0, 12'h800, 5'd8, 5'd9), 64'd3, 64'h0,
                  64'hA5A5_5A5A_C3C3_3C3C);
        send_beat(make_ins(1'b1, 1'b1, 1'b0, 12'hFC0, 5'd8, 5'd9), 64'd1, 64'd2, 64'h0);
        // register offset sum wraps through 2^64
        send_beat(make_ins(1'b0, 1'b1, 1'b0, 12'h87F, 5'd10, 5'd11), '1, 64'd4, 64'h0);
        // pre-index with most negative immediate, post-index with most positive
        send_beat(make_ins(1'b1, 1'b0, 1'b0, index_imm(9'h100, 1'b1), 5'd12, 5'd13),
                  64'h1000, 64'h0, 64'h1122_3344_5566_7788);
        send_beat(make_ins(1'b1, 1'b1, 1'b0, index_imm(9'h0FF, 1'b0), 5'd14, 5'd15),
                  64'hF00, 64'h0, 64'h0);
        // load with base and destination the same register
        send_beat(make_ins(1'b1, 1'b1, 1'b0, index_imm(9'h000, 1'b1), 5'd7, 5'd7),
                  64'hF00, 64'h0, 64'h0);
        // post-index of -1 from zero: writeback wraps to all ones
        send_beat(make_ins(1'b0, 1'b0, 1'b0, index_imm(9'h1FF, 1'b0), 5'd16, 5'd17),
                  64'h0, 64'h0, 64'hDEAD_BEEF_CAFE_F00D);
        // x access straddling the top of the 64-bit address space
        send_beat(make_ins(1'b1, 1'b0, 1'b1, 12'h000, 5'd18, 5'd19), 64'hFFFF_FFFF_FFFF_FFFC,
                  64'h0, 64'h0F1E_2D3C_4B5A_6978);
        send_beat(make_ins(1'b1, 1'b1, 1'b1, 12'h000, 5'd18, 5'd20), 64'hFFFF_FFFF_FFFF_FFFC,
                  64'h0, 64'h0);
        // x load from the last word wrapping into word 0
        send_beat(make_ins(1'b1, 1'b1, 1'b1, 12'h000, 5'd21, 5'd22), 64'h3FFE, 64'h0, 64'h0);
        // all-zero and all-one instruction words
        send_beat(32'h0000_0000, 64'h0, 64'h0, 64'h0);
        send_beat(32'hFFFF_FFFF, '1, '1, '1);
        // ignored bits all set on a w store
        send_beat(make_ins(1'b0, 1'b0, 1'b1, 12'h010, 5'd23, 5'd24) | ~DECODED_BITS, 64'h0,
                  '1, '1);
        send_beat(make_ins(1'b0, 1'b1, 1'b1, 12'h010, 5'd23, 5'd25), 64'h0, 64'h0, 64'h0);
        // w load, post-index, highest register numbers
        send_beat(make_ins(1'b0, 1'b1, 1'b0, index_imm(9'h004, 1'b0), 5'd31, 5'd31),
                  64'h40, 64'h0, 64'h0);
        wait_drained();
    endtask

    // results are held back for a long stretch while requests keep coming
    task automatic test_pressure();
        int i;
        send_eager      = 1'b1;
        hold_off_cycles = 80;
        for (i = 0; i < 16; i++)
            send_beat(make_ins(i[0], i[1], 1'b1, 12'(i), 5'(i), 5'(i + 1)), 64'h200, 64'h0,
                      {$urandom, $urandom});
        send_eager = 1'b0;
        wait_drained();
    endtask

    // random transfers, mostly clustered on a hot address window so loads see stores
    task automatic test_random(input int count);
        int          i;
        int          phase;
        int          mode;
        logic [63:0] hot_base;
        logic [63:0] base;
        logic [63:0] off;
        logic [11:0] imm12;
        logic [8:0]  imm9;
        logic [31:0] ins;
        hot_base = '0;
        for (i = 0; i < count; i++)
        begin
            // rotate pacing: both random, sender eager, receiver eager, both eager
            phase      = (i / 150) % 4;
            send_eager = (phase == 1) || (phase == 3);
            recv_eager = (phase >= 2);
            if (i % 50 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: hot_base = 64'h0;
                    1: hot_base = 64'(MEM_WORDS * 4 - 32);   // top of ram, index wrap
                    2: hot_base = 64'hFFFF_FFFF_FFFF_FFC0;   // top of address space
                    default: hot_base = {$urandom, $urandom};
                endcase
            end
            base = ($urandom_range(0, 9) < 8) ? hot_base + 64'($urandom_range(0, 31))
                                              : {$urandom, $urandom};
            off  = {$urandom, $urandom};
            mode = $urandom_range(0, 3);
            case (mode)
                0:
                begin
                    imm12 = ($urandom_range(0, 7) == 0) ? 12'($urandom)
                                                        : 12'($urandom_range(0, 7));
                end
                1:
                begin
                    imm12 = {1'b1, 11'($urandom)};
                    if ($urandom_range(0, 3) != 0)
                        off = 64'($urandom_range(0, 15)) - 64'd8;
                end
                default:
                begin
                    imm9  = ($urandom_range(0, 3) == 0) ? 9'($urandom)
                                                        : 9'($urandom_range(0, 16)) - 9'd8;
                    imm12 = index_imm(imm9, mode == 2);
                    imm12[0] = 1'($urandom);
                end
            endcase
            ins = make_ins(1'($urandom), 1'($urandom), mode == 0, imm12,
                           5'($urandom), 5'($urandom));
            ins = ins | ($urandom & ~DECODED_BITS);
            send_beat(ins, base, off, {$urandom, $urandom});
        end
        send_eager = 1'b0;
        recv_eager = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        push            = 1'b0;
        instruction     = '0;
        base_value      = '0;
        offset_value    = '0;
        store_value     = '0;
        send_eager      = 1'b0;
        recv_eager      = 1'b0;
        hold_off_cycles = 0;
        error_count     = 0;
        n_loads         = 0;
        n_stores        = 0;
        n_writebacks    = 0;
        n_results       = 0;
        foreach (mem_image[w])
            mem_image[w] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_pressure();
        test_random(1200);

        // catch any stray result beats after the last expected one
        repeat (50) @(posedge clk);

        $display("run covered %0d loads and %0d stores, %0d with base writeback",
                 n_loads, n_stores, n_writebacks);
        $display("%0d result beats checked across all four addressing modes, %0d mismatches",
                 n_results, error_count);
        if (error_count == 0)
            $display("a64_load_store_unit_core_tb passed");
        else
            $display("a64_load_store_unit_core_tb failed");
        $finish;
    end

endmodule
